// ----- hdl/sdp_pkg.sv -----
package sdp_pkg;

  // one payload byte of the descriptor
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  // one parsed field
  typedef struct packed {
    logic [3:0]  field_kind;
    logic [39:0] field_value;
    logic [7:0]  comp_tag;
    logic        descriptor_ok;
    logic        last_result;
  } out_t;

  // results of one parse step: up to a field beat and an end beat
  typedef struct packed {
    logic [1:0] cnt;
    out_t       first;
    out_t       second;
  } step_res_t;

  localparam logic [3:0] K_IDENT    = 4'd0;
  localparam logic [3:0] K_EVENT    = 4'd1;
  localparam logic [3:0] K_CANCEL   = 4'd2;
  localparam logic [3:0] K_FLAGS    = 4'd3;
  localparam logic [3:0] K_COMP     = 4'd4;
  localparam logic [3:0] K_DURATION = 4'd5;
  localparam logic [3:0] K_UPID_TYP = 4'd6;
  localparam logic [3:0] K_UPID_BYT = 4'd7;
  localparam logic [3:0] K_TYPE_ID  = 4'd8;
  localparam logic [3:0] K_SEG_NUM  = 4'd9;
  localparam logic [3:0] K_SEG_EXP  = 4'd10;
  localparam logic [3:0] K_SUB_NUM  = 4'd11;
  localparam logic [3:0] K_SUB_EXP  = 4'd12;
  localparam logic [3:0] K_END      = 4'd13;

  localparam logic [7:0] TYPE_SUB_A = 8'h34;
  localparam logic [7:0] TYPE_SUB_B = 8'h36;

endpackage

// ----- hdl/sdp_step.sv -----
module sdp_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  sdp_pkg::in_t      beat,
  output sdp_pkg::step_res_t step
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_IDENT  = 4'd1;
  localparam logic [3:0] PH_EVENT  = 4'd2;
  localparam logic [3:0] PH_CANCEL = 4'd3;
  localparam logic [3:0] PH_FLAGS  = 4'd4;
  localparam logic [3:0] PH_COUNT  = 4'd5;
  localparam logic [3:0] PH_TAG    = 4'd6;
  localparam logic [3:0] PH_OFFSET = 4'd7;
  localparam logic [3:0] PH_DUR    = 4'd8;
  localparam logic [3:0] PH_UTYPE  = 4'd9;
  localparam logic [3:0] PH_ULEN   = 4'd10;
  localparam logic [3:0] PH_UBYTES = 4'd11;
  localparam logic [3:0] PH_TYPEID = 4'd12;
  localparam logic [3:0] PH_SEG    = 4'd13;
  localparam logic [3:0] PH_SUBSEG = 4'd14;

  logic [3:0]  phase, phase_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [39:0] acc, acc_next;
  logic [7:0]  held_tag, held_tag_next;
  logic [7:0]  remaining, remaining_next;
  logic        dur_present, dur_present_next;
  logic [7:0]  held_type_id, held_type_id_next;
  logic        error_seen, error_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      byte_index   <= '0;
      acc          <= '0;
      held_tag     <= '0;
      remaining    <= '0;
      dur_present  <= 1'b0;
      held_type_id <= '0;
      error_seen   <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      acc          <= acc_next;
      held_tag     <= held_tag_next;
      remaining    <= remaining_next;
      dur_present  <= dur_present_next;
      held_type_id <= held_type_id_next;
      error_seen   <= error_seen_next;
    end
  end

  always_comb begin
    logic [7:0]    b;
    logic          fv;
    sdp_pkg::out_t fld;
    sdp_pkg::out_t endr;
    logic [3:0]    p;
    logic [2:0]    bi;
    logic [39:0]   a;
    logic [7:0]    tg;
    logic [7:0]    rem;
    logic          dp;
    logic [7:0]    tid;
    logic          err;
    logic [3:0]    after_comp;

    b          = beat.in_byte;
    fv         = 1'b0;
    fld        = '0;
    endr       = '0;
    p          = phase;
    bi         = byte_index;
    a          = acc;
    tg         = held_tag;
    rem        = remaining;
    dp         = dur_present;
    tid        = held_type_id;
    err        = error_seen;
    after_comp = PH_IDLE;

    // first mark restarts the parse from a clean state
    if (beat.first_byte) begin
      p   = PH_IDENT;
      bi  = '0;
      a   = '0;
      tg  = '0;
      rem = '0;
      dp  = 1'b0;
      tid = '0;
      err = 1'b0;
    end

    a  = {a[31:0], b};
    bi = bi + 3'd1;

    unique case (p)
      PH_IDENT, PH_EVENT: begin
        if (bi >= 3'd4) begin
          fv                = 1'b1;
          fld.field_kind    = (p == PH_IDENT) ? sdp_pkg::K_IDENT : sdp_pkg::K_EVENT;
          fld.field_value   = {8'd0, a[31:0]};
          p                 = (p == PH_IDENT) ? PH_EVENT : PH_CANCEL;
          bi                = '0;
          a                 = '0;
        end
      end
      PH_CANCEL: begin
        fv              = 1'b1;
        fld.field_kind  = sdp_pkg::K_CANCEL;
        fld.field_value = {39'd0, b[7]};
        p               = b[7] ? PH_IDLE : PH_FLAGS;
        bi              = '0;
        a               = '0;
      end
      PH_FLAGS: begin
        dp              = b[6];
        after_comp      = dp ? PH_DUR : PH_UTYPE;
        fv              = 1'b1;
        fld.field_kind  = sdp_pkg::K_FLAGS;
        // not-restricted forces web, no-blackout, archive and device to all-allowed
        fld.field_value = {33'd0, b[7], b[6], (b[5] ? 5'h1F : b[4:0])};
        p               = b[7] ? after_comp : PH_COUNT;
        bi              = '0;
        a               = '0;
      end
      PH_COUNT: begin
        rem = b;
        p   = (b == 8'd0) ? (dp ? PH_DUR : PH_UTYPE) : PH_TAG;
        bi  = '0;
        a   = '0;
      end
      PH_TAG: begin
        tg = b;
        p  = PH_OFFSET;
        bi = '0;
        a  = '0;
      end
      PH_OFFSET: begin
        if (bi >= 3'd5) begin
          fv                = 1'b1;
          fld.field_kind    = sdp_pkg::K_COMP;
          fld.field_value   = {7'd0, a[32:0]};
          fld.comp_tag      = tg;
          rem               = rem - 8'd1;
          p                 = (rem == 8'd0) ? (dp ? PH_DUR : PH_UTYPE) : PH_TAG;
          bi                = '0;
          a                 = '0;
        end
      end
      PH_DUR: begin
        if (bi >= 3'd5) begin
          fv              = 1'b1;
          fld.field_kind  = sdp_pkg::K_DURATION;
          fld.field_value = a;
          p               = PH_UTYPE;
          bi              = '0;
          a               = '0;
        end
      end
      PH_UTYPE: begin
        fv              = 1'b1;
        fld.field_kind  = sdp_pkg::K_UPID_TYP;
        fld.field_value = {32'd0, b};
        p               = PH_ULEN;
        bi              = '0;
        a               = '0;
      end
      PH_ULEN: begin
        rem = b;
        p   = (b == 8'd0) ? PH_TYPEID : PH_UBYTES;
        bi  = '0;
        a   = '0;
      end
      PH_UBYTES: begin
        fv              = 1'b1;
        fld.field_kind  = sdp_pkg::K_UPID_BYT;
        fld.field_value = {32'd0, b};
        rem             = rem - 8'd1;
        bi              = '0;
        if (rem == 8'd0) begin
          p = PH_TYPEID;
          a = '0;
        end
      end
      PH_TYPEID: begin
        tid             = b;
        fv              = 1'b1;
        fld.field_kind  = sdp_pkg::K_TYPE_ID;
        fld.field_value = {32'd0, b};
        p               = PH_SEG;
        bi              = '0;
        a               = '0;
      end
      PH_SEG: begin
        fv              = 1'b1;
        fld.field_value = {32'd0, b};
        if (bi == 3'd1) begin
          fld.field_kind = sdp_pkg::K_SEG_NUM;
        end else begin
          fld.field_kind = sdp_pkg::K_SEG_EXP;
          p  = (tid == sdp_pkg::TYPE_SUB_A || tid == sdp_pkg::TYPE_SUB_B) ?
               PH_SUBSEG : PH_IDLE;
          bi = '0;
          a  = '0;
        end
      end
      PH_SUBSEG: begin
        fv              = 1'b1;
        fld.field_value = {32'd0, b};
        if (bi == 3'd1) begin
          fld.field_kind = sdp_pkg::K_SUB_NUM;
        end else begin
          fld.field_kind = sdp_pkg::K_SUB_EXP;
          p  = PH_IDLE;
          bi = '0;
          a  = '0;
        end
      end
      default: begin
        // excess byte, or byte with no first mark before it
        err = 1'b1;
        p   = PH_IDLE;
        bi  = '0;
        a   = '0;
      end
    endcase

    if (beat.last_byte) begin
      endr.field_kind    = sdp_pkg::K_END;
      endr.descriptor_ok = (p == PH_IDLE) && !err;
      endr.last_result   = 1'b1;
      p  = PH_IDLE;
      bi = '0;
      a  = '0;
    end

    step.cnt    = {1'b0, fv} + {1'b0, beat.last_byte};
    step.first  = fv ? fld : endr;
    step.second = endr;

    phase_next        = p;
    byte_index_next   = bi;
    acc_next          = a;
    held_tag_next     = tg;
    remaining_next    = rem;
    dur_present_next  = dp;
    held_type_id_next = tid;
    error_seen_next   = err;
  end

endmodule

// ----- hdl/segmentation_descriptor_parser.sv -----
// Channel   Dir  Handshake                Payload
// desc      in   desc_valid / desc_stall  sdp_pkg::in_t  (byte, first and last marks)
// res       out  res_valid / res_stall    sdp_pkg::out_t (kind, value, tag, ok, last)
//
// One payload byte per cycle while desc_stall is low. The parse step sits
// between the parser state registers and a small result queue (DEPTH beats).
// A byte gives at most two beats (a field and the end beat), so a last-marked
// byte that also closes a field puts an extra beat into the queue, which absorbs it.
// desc_stall rises while fewer than two queue slots are free.
// Synchronous reset clears parser state and the queue; first result can leave
// the cycle after its byte is taken.
module segmentation_descriptor_parser #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          desc_valid,
  output logic          desc_stall,
  input  sdp_pkg::in_t  desc,
  output logic          res_valid,
  input  logic          res_stall,
  output sdp_pkg::out_t res
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] STALL_AT  = CNT_W'(DEPTH - 2);

  logic               take;
  logic               pop;
  sdp_pkg::step_res_t step;
  logic [1:0]         push_n;

  sdp_pkg::out_t      queue [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   wr_ptr1, wr_ptr2;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]   count, count_next;

  assign take = desc_valid && !desc_stall;
  assign pop  = res_valid && !res_stall;

  // room for a full two-beat step must be there before a byte is taken
  assign desc_stall = (count > STALL_AT);

  sdp_step u_step (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .beat (desc),
    .step (step)
  );

  assign push_n = take ? step.cnt : 2'd0;

  // queue pointers wrap explicitly, so the depth need not be a power of two
  assign wr_ptr1 = (wr_ptr  == LAST_SLOT) ? '0 : wr_ptr  + 1'b1;
  assign wr_ptr2 = (wr_ptr1 == LAST_SLOT) ? '0 : wr_ptr1 + 1'b1;

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (push_n == 2'd2) begin
      wr_ptr_next = wr_ptr2;
    end else if (push_n == 2'd1) begin
      wr_ptr_next = wr_ptr1;
    end
    rd_ptr_next = rd_ptr;
    if (pop) begin
      rd_ptr_next = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
    end
    count_next = count + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // payload slots: no reset needed
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= step.first;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr1] <= step.second;
    end
  end

  assign res_valid = (count != '0);
  assign res       = queue[rd_ptr];

  // queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue over depth");

  // a last-marked byte always leaves at least its end beat queued
  a_end_queued: assert property (@(posedge clk) disable iff (rst)
    (take && desc.last_byte) |=> res_valid)
    else $error("end beat missing after last byte");

  // the closing mark goes with the end kind and nothing else
  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.last_result == (res.field_kind == sdp_pkg::K_END)))
    else $error("last_result and end kind disagree");

  // validity flag only on the end beat
  a_ok_on_end: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.descriptor_ok) |-> res.last_result)
    else $error("descriptor_ok outside end beat");

endmodule
